// ----- hw/rtl/ndnz_pkg.sv -----
`timescale 1ns / 1ps
// ndnz_pkg: shared types and constants of the ND to tiled NZ address generator.
// No dependencies.
package ndnz_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;
    localparam int DIM_W      = 17;
    localparam int CNT_W      = 16;
    localparam int TW_W       = 7;
    localparam int SPAN_W     = 24;
    localparam int DATA_W     = 64;

    localparam logic [CFG_ADDR_W-1:0] REG_NUM_COLS    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_ROWS    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_BATCHES = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TILE_WIDTH  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PADDED_ROWS = 3'd4;

    localparam logic [DIM_W-1:0] DIM_MAX = 17'h10000;

    // Effective shape handed from the config unit to the index datapath
    typedef struct packed {
        logic              ready;
        logic [DIM_W-1:0]  cols;
        logic [DIM_W-1:0]  rows;
        logic [DIM_W-1:0]  batches;
        logic [TW_W-1:0]   tw;
        logic [SPAN_W-1:0] span;
    } ndnz_dims_t;

endpackage

// ----- hw/rtl/ndnz_if.sv -----
`timescale 1ns / 1ps
// ndnz_if: valid/ready channel interfaces for elements, address results and config writes.
// Depends on ndnz_pkg.
interface ndnz_elem_if;
    logic                        valid;
    logic                        ready;
    logic [ndnz_pkg::DATA_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink (input valid, input element_value, output ready);
endinterface

interface ndnz_addr_if #(
    parameter int INDEX_BITS = 40
);
    logic                        valid;
    logic                        ready;
    logic [INDEX_BITS-1:0]       nd_index;
    logic [INDEX_BITS-1:0]       nz_index;
    logic [ndnz_pkg::DATA_W-1:0] data_out;
    logic                        last_element;

    modport source (output valid, output nd_index, output nz_index, output data_out,
                    output last_element, input ready);
    modport sink (input valid, input nd_index, input nz_index, input data_out,
                  input last_element, output ready);
endinterface

interface ndnz_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ndnz_pkg::CFG_ADDR_W-1:0] index;
    logic [ndnz_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/ndnz_cfg.sv -----
`timescale 1ns / 1ps
// ndnz_cfg: config registers, range clamping and derived tile span / batch stride.
// Depends on ndnz_pkg and ndnz_cfg_if.
module ndnz_cfg #(
    parameter int INDEX_BITS     = 40,
    parameter int MAX_TILE_WIDTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    ndnz_cfg_if.sink               cfg,
    output ndnz_pkg::ndnz_dims_t   dims,
    output logic [INDEX_BITS-1:0]  batch_stride
);
    import ndnz_pkg::*;

    localparam logic [1:0] ST_READY = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;
    localparam logic [1:0] ST_MUL   = 2'd3;

    localparam logic [TW_W-1:0] TW_MAX   = TW_W'(MAX_TILE_WIDTH);
    localparam logic [TW_W-1:0] TW_MIN   = 7'd2;
    localparam logic [4:0]      IDX_TOP  = 5'(DIM_W - 1);
    localparam int              PROD_W   = 2 * DIM_W;

    logic [DIM_W-1:0]      num_cols_reg, num_rows_reg, num_batches_reg, padded_rows_reg;
    logic [TW_W-1:0]       tile_width_reg;
    logic [1:0]            state_reg, state_next;
    logic [4:0]            idx_reg, idx_next;
    logic [TW_W-1:0]       rem_reg, rem_next;
    logic [DIM_W-1:0]      rounded_reg, rounded_next;
    logic [SPAN_W-1:0]     span_reg, span_next;
    logic [INDEX_BITS-1:0] stride_reg, stride_next;

    logic [DIM_W-1:0]  cols_eff, rows_eff, batches_eff, prow_eff;
    logic [TW_W-1:0]   tw_eff;
    logic [TW_W:0]     rem_shift;
    logic [PROD_W-1:0] stride_prod;
    logic [SPAN_W-1:0] span_prod;
    logic              cfg_wr;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (v[DIM_W-1] && (v[DIM_W-2:0] != '0))
            r = DIM_MAX;
        return r;
    endfunction

    assign cfg_wr    = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;

    assign cols_eff    = clamp_dim(num_cols_reg);
    assign rows_eff    = clamp_dim(num_rows_reg);
    assign batches_eff = clamp_dim(num_batches_reg);
    assign prow_eff    = clamp_dim(padded_rows_reg);

    always_comb
    begin
        if (tile_width_reg < TW_MIN)
            tw_eff = TW_MIN;
        else if (tile_width_reg > TW_MAX)
            tw_eff = TW_MAX;
        else
            tw_eff = tile_width_reg;
    end

    // remainder of cols / tw, one dividend bit per cycle
    assign rem_shift   = {rem_reg, cols_eff[idx_reg]};
    assign stride_prod = rounded_reg * prow_eff;
    assign span_prod   = prow_eff * tw_eff;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        rem_next     = rem_reg;
        rounded_next = rounded_reg;
        span_next    = span_reg;
        stride_next  = stride_reg;
        case (state_reg)
            ST_DIV:
            begin
                if (rem_shift >= {1'b0, tw_eff})
                    rem_next = TW_W'(rem_shift - {1'b0, tw_eff});
                else
                    rem_next = TW_W'(rem_shift);
                idx_next = idx_reg - 5'd1;
                if (idx_reg == '0)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (rem_reg != '0)
                    rounded_next = cols_eff + DIM_W'(tw_eff - rem_reg);
                else
                    rounded_next = cols_eff;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                stride_next = INDEX_BITS'(stride_prod);
                span_next   = span_prod;
                state_next  = ST_READY;
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
        if (cfg_wr)
        begin
            state_next = ST_DIV;
            idx_next   = IDX_TOP;
            rem_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg    <= DIM_W'(1);
            num_rows_reg    <= DIM_W'(1);
            num_batches_reg <= DIM_W'(1);
            tile_width_reg  <= TW_W'(16);
            padded_rows_reg <= DIM_W'(16);
            state_reg       <= ST_DIV;
            idx_reg         <= IDX_TOP;
            rem_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rem_reg   <= rem_next;
            if (cfg_wr)
            begin
                case (cfg.index)
                    REG_NUM_COLS:    num_cols_reg    <= cfg.data;
                    REG_NUM_ROWS:    num_rows_reg    <= cfg.data;
                    REG_NUM_BATCHES: num_batches_reg <= cfg.data;
                    REG_TILE_WIDTH:  tile_width_reg  <= cfg.data[TW_W-1:0];
                    REG_PADDED_ROWS: padded_rows_reg <= cfg.data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rounded_reg <= rounded_next;
        span_reg    <= span_next;
        stride_reg  <= stride_next;
    end

    assign dims.ready   = (state_reg == ST_READY);
    assign dims.cols    = cols_eff;
    assign dims.rows    = rows_eff;
    assign dims.batches = batches_eff;
    assign dims.tw      = tw_eff;
    assign dims.span    = span_reg;
    assign batch_stride = stride_reg;

    a_write_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (state_reg == ST_DIV) && (idx_reg == IDX_TOP))
        else $error("config write did not restart stride computation");

    a_div_to_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && (idx_reg == '0) && !cfg_wr |=> state_reg == ST_ROUND)
        else $error("divider did not finish after last dividend bit");

    a_rem_below_tw: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> rem_reg < tw_eff)
        else $error("remainder not below tile width");

endmodule

// ----- hw/rtl/ndnz_core.sv -----
`timescale 1ns / 1ps
// ndnz_core: ND position counters, NZ index arithmetic and result register.
// Depends on ndnz_pkg, ndnz_elem_if and ndnz_addr_if.
module ndnz_core #(
    parameter int INDEX_BITS     = 40,
    parameter int MAX_TILE_WIDTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    ndnz_elem_if.sink              elem,
    ndnz_addr_if.source            addr,
    input  ndnz_pkg::ndnz_dims_t   dims,
    input  logic [INDEX_BITS-1:0]  batch_stride
);
    import ndnz_pkg::*;

    localparam int CIT_W = (MAX_TILE_WIDTH > 2) ? $clog2(MAX_TILE_WIDTH) : 1;

    logic [CNT_W-1:0]      col_count_reg, col_count_next;
    logic [CIT_W-1:0]      col_in_tile_reg, col_in_tile_next;
    logic [INDEX_BITS-1:0] tile_base_reg, tile_base_next;
    logic [CNT_W-1:0]      row_count_reg, row_count_next;
    logic [CNT_W-1:0]      batch_count_reg, batch_count_next;
    logic [INDEX_BITS-1:0] batch_base_reg, batch_base_next;
    logic [INDEX_BITS-1:0] linear_count_reg, linear_count_next;

    logic                  out_valid_reg;
    logic [INDEX_BITS-1:0] nd_reg, nz_reg;
    logic [DATA_W-1:0]     data_reg;
    logic                  last_reg;

    logic                     elem_acc;
    logic                     col_end, row_end, batch_end, last_c, tile_end;
    logic [CNT_W+TW_W-1:0]    row_off;
    logic [INDEX_BITS-1:0]    nz_c;

    assign elem.ready = dims.ready && (!out_valid_reg || addr.ready);
    assign elem_acc   = elem.valid && elem.ready;

    assign col_end   = ({1'b0, col_count_reg} + DIM_W'(1)) >= dims.cols;
    assign row_end   = ({1'b0, row_count_reg} + DIM_W'(1)) >= dims.rows;
    assign batch_end = ({1'b0, batch_count_reg} + DIM_W'(1)) >= dims.batches;
    assign last_c    = col_end && row_end && batch_end;
    assign tile_end  = (TW_W'(col_in_tile_reg) + TW_W'(1)) >= dims.tw;

    assign row_off = row_count_reg * dims.tw;
    assign nz_c    = batch_base_reg + tile_base_reg + INDEX_BITS'(row_off)
                     + INDEX_BITS'(col_in_tile_reg);

    always_comb
    begin
        col_count_next    = col_count_reg;
        col_in_tile_next  = col_in_tile_reg;
        tile_base_next    = tile_base_reg;
        row_count_next    = row_count_reg;
        batch_count_next  = batch_count_reg;
        batch_base_next   = batch_base_reg;
        linear_count_next = linear_count_reg;
        if (elem_acc)
        begin
            if (last_c)
            begin
                col_count_next    = '0;
                col_in_tile_next  = '0;
                tile_base_next    = '0;
                row_count_next    = '0;
                batch_count_next  = '0;
                batch_base_next   = '0;
                linear_count_next = '0;
            end
            else
            begin
                linear_count_next = linear_count_reg + INDEX_BITS'(1);
                if (!col_end)
                begin
                    col_count_next = col_count_reg + CNT_W'(1);
                    if (tile_end)
                    begin
                        col_in_tile_next = '0;
                        tile_base_next   = tile_base_reg + INDEX_BITS'(dims.span);
                    end
                    else
                        col_in_tile_next = col_in_tile_reg + CIT_W'(1);
                end
                else
                begin
                    col_count_next   = '0;
                    col_in_tile_next = '0;
                    tile_base_next   = '0;
                    if (!row_end)
                        row_count_next = row_count_reg + CNT_W'(1);
                    else
                    begin
                        row_count_next   = '0;
                        batch_count_next = batch_count_reg + CNT_W'(1);
                        batch_base_next  = batch_base_reg + batch_stride;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg    <= '0;
            col_in_tile_reg  <= '0;
            tile_base_reg    <= '0;
            row_count_reg    <= '0;
            batch_count_reg  <= '0;
            batch_base_reg   <= '0;
            linear_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            col_count_reg    <= col_count_next;
            col_in_tile_reg  <= col_in_tile_next;
            tile_base_reg    <= tile_base_next;
            row_count_reg    <= row_count_next;
            batch_count_reg  <= batch_count_next;
            batch_base_reg   <= batch_base_next;
            linear_count_reg <= linear_count_next;
            if (elem_acc)
                out_valid_reg <= 1'b1;
            else if (addr.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_acc)
        begin
            nd_reg   <= linear_count_reg;
            nz_reg   <= nz_c;
            data_reg <= elem.element_value;
            last_reg <= last_c;
        end
    end

    assign addr.valid        = out_valid_reg;
    assign addr.nd_index     = nd_reg;
    assign addr.nz_index     = nz_reg;
    assign addr.data_out     = data_reg;
    assign addr.last_element = last_reg;

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        elem_acc && last_c |=> (linear_count_reg == '0) && (row_count_reg == '0)
            && (batch_count_reg == '0) && (batch_base_reg == '0) && (tile_base_reg == '0))
        else $error("counters not cleared after last word");

    a_nd_steps: assert property (@(posedge clk) disable iff (!rst_n)
        elem_acc && !last_c |=> linear_count_reg == INDEX_BITS'($past(linear_count_reg) + 1'b1))
        else $error("ND index did not advance by one");

    a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && addr.ready && !elem_acc |=> !out_valid_reg)
        else $error("result word repeated after being taken");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !addr.ready |-> !elem_acc)
        else $error("word accepted over a stalled result");

endmodule

// ----- hw/rtl/nd_to_tiled_nz_address_generator.sv -----
`timescale 1ns / 1ps
// nd_to_tiled_nz_address_generator: top level of the ND to tiled NZ address generator.
// Depends on ndnz_pkg, ndnz_if, ndnz_cfg and ndnz_core.
//
// Usage:
//   elem  - element words in row-major ND order (batch, row, column).
//   addr  - one result word per element: ND index, NZ index, the element
//           value and a flag on the final element of the tensor.
//   cfg   - register writes: 0 num_cols, 1 num_rows, 2 num_batches,
//           3 tile_width, 4 padded_rows. Always ready.
// Latency: a result is valid the cycle after its element is taken.
// Throughput: one element per cycle while the receiver takes each result;
//   the result register is refilled in the same cycle it is taken.
// After reset and after every config write the block recomputes the
//   batch stride and tile span (remainder divider plus a round and a multiply
//   step), and elem.ready stays low until that is done.
// When the receiver stalls, the result is held and elem.ready drops until
//   it is taken. Position counters clear at reset and after the last element.
module nd_to_tiled_nz_address_generator #(
    parameter int INDEX_BITS     = 40,
    parameter int MAX_TILE_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    ndnz_elem_if.sink   elem,
    ndnz_addr_if.source addr,
    ndnz_cfg_if.sink    cfg
);
    import ndnz_pkg::*;

    ndnz_dims_t            dims;
    logic [INDEX_BITS-1:0] batch_stride;

    ndnz_cfg #(
        .INDEX_BITS     (INDEX_BITS),
        .MAX_TILE_WIDTH (MAX_TILE_WIDTH)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .dims         (dims),
        .batch_stride (batch_stride)
    );

    ndnz_core #(
        .INDEX_BITS     (INDEX_BITS),
        .MAX_TILE_WIDTH (MAX_TILE_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .elem         (elem),
        .addr         (addr),
        .dims         (dims),
        .batch_stride (batch_stride)
    );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking testbench of nd_to_tiled_nz_address_generator. Drives element words
// under random tensor shapes and random stalls, and checks each address word against a
// local index predictor. Depends on ndnz_pkg, ndnz_if and the address generator RTL.
module tb_top;
    import ndnz_pkg::*;

    localparam int IDX_W       = 40;
    localparam int TILE_MAX    = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int ELEM_TARGET = 1600;

    typedef struct packed {
        logic [IDX_W-1:0]  nd;
        logic [IDX_W-1:0]  nz;
        logic [DATA_W-1:0] data;
        logic              last;
    } addr_word_t;

    logic clk;
    logic rst_n;

    ndnz_elem_if                       elem ();
    ndnz_addr_if #(.INDEX_BITS(IDX_W)) addr ();
    ndnz_cfg_if                        cfg ();

    nd_to_tiled_nz_address_generator #(
        .INDEX_BITS     (IDX_W),
        .MAX_TILE_WIDTH (TILE_MAX)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .elem  (elem),
        .addr  (addr),
        .cfg   (cfg)
    );

    logic [DATA_W-1:0] element_q[$];
    addr_word_t        nz_addr_q[$];

    int send_idle_pct;
    int recv_idle_pct;
    int fail_count;
    int words_checked;
    int tensor_ends;
    int shapes_run;
    int quiet_cycles;

    // shape registers as the block sees them
    logic [DIM_W-1:0] shape_cols, shape_rows, shape_batches, shape_prow;
    logic [TW_W-1:0]  shape_tw;

    // walk position inside the tensor
    logic [CNT_W-1:0] pos_col, pos_row, pos_batch;
    logic [5:0]       pos_col_in_tile;
    logic [IDX_W-1:0] tile_off, batch_off, nd_next;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > DIM_MAX)
            return 32'(DIM_MAX);
        return 32'(v);
    endfunction

    function automatic int unsigned clamp_tile(input logic [TW_W-1:0] v);
        if (v < 2)
            return 2;
        if (v > TILE_MAX)
            return TILE_MAX;
        return 32'(v);
    endfunction

    function automatic void clear_position();
        pos_col         = '0;
        pos_col_in_tile = '0;
        tile_off        = '0;
        pos_row         = '0;
        pos_batch       = '0;
        batch_off       = '0;
        nd_next         = '0;
    endfunction

    // Indices of the current element, then advance the walk.
    function automatic addr_word_t step_nz_position(input logic [DATA_W-1:0] value);
        int unsigned cols, rows, batches, tw, prow;
        logic [IDX_W-1:0] span, tiles;
        logic col_end, row_end, batch_end;
        addr_word_t w;
        cols      = clamp_dim(shape_cols);
        rows      = clamp_dim(shape_rows);
        batches   = clamp_dim(shape_batches);
        prow      = clamp_dim(shape_prow);
        tw        = clamp_tile(shape_tw);
        span      = IDX_W'(prow * tw);
        tiles     = IDX_W'((cols + tw - 1) / tw);
        col_end   = (32'(pos_col) + 1) >= cols;
        row_end   = (32'(pos_row) + 1) >= rows;
        batch_end = (32'(pos_batch) + 1) >= batches;
        w.nd      = nd_next;
        w.nz      = batch_off + tile_off + IDX_W'(pos_row) * IDX_W'(tw)
                    + IDX_W'(pos_col_in_tile);
        w.data    = value;
        w.last    = col_end && row_end && batch_end;
        if (w.last)
        begin
            clear_position();
            return w;
        end
        nd_next = nd_next + 1'b1;
        if (!col_end)
        begin
            pos_col = pos_col + 1'b1;
            if ((32'(pos_col_in_tile) + 1) >= tw)
            begin
                pos_col_in_tile = '0;
                tile_off        = tile_off + span;
            end
            else
            begin
                pos_col_in_tile = pos_col_in_tile + 1'b1;
            end
            return w;
        end
        pos_col         = '0;
        pos_col_in_tile = '0;
        tile_off        = '0;
        if (!row_end)
        begin
            pos_row = pos_row + 1'b1;
            return w;
        end
        pos_row   = '0;
        pos_batch = pos_batch + 1'b1;
        batch_off = batch_off + tiles * span;
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // element driver
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic taken;
        if (!rst_n)
        begin
            elem.valid         <= 1'b0;
            elem.element_value <= '0;
        end
        else
        begin
            taken = elem.valid && elem.ready;
            if (taken)
                void'(element_q.pop_front());
            if (taken || !elem.valid)
            begin
                if (element_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    elem.valid         <= 1'b1;
                    elem.element_value <= element_q[0];
                end
                else
                begin
                    elem.valid <= 1'b0;
                end
            end
        end
    end

    // shape tracking, prediction and result check
    always @(posedge clk or negedge rst_n)
    begin : monitor
        addr_word_t got;
        addr_word_t want;
        if (!rst_n)
        begin
            addr.ready    <= 1'b0;
            shape_cols    = 1;
            shape_rows    = 1;
            shape_batches = 1;
            shape_tw      = 16;
            shape_prow    = 16;
            clear_position();
            nz_addr_q.delete();
        end
        else
        begin
            addr.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_NUM_COLS:    shape_cols    = cfg.data;
                    REG_NUM_ROWS:    shape_rows    = cfg.data;
                    REG_NUM_BATCHES: shape_batches = cfg.data;
                    REG_TILE_WIDTH:  shape_tw      = cfg.data[TW_W-1:0];
                    REG_PADDED_ROWS: shape_prow    = cfg.data;
                    default: ;
                endcase
            end
            if (elem.valid && elem.ready)
                nz_addr_q.insert(nz_addr_q.size(), step_nz_position(elem.element_value));
            if (addr.valid && addr.ready)
            begin
                got.nd   = addr.nd_index;
                got.nz   = addr.nz_index;
                got.data = addr.data_out;
                got.last = addr.last_element;
                words_checked++;
                if (nz_addr_q.size() == 0)
                begin
                    $error("address word with no element outstanding: nd_index %0h",
                           got.nd);
                    fail_count++;
                end
                else
                begin
                    want = nz_addr_q.pop_front();
                    if (want.last)
                        tensor_ends++;
                    check_field("nd_index", 64'(want.nd), 64'(got.nd));
                    check_field("nz_index", 64'(want.nz), 64'(got.nz));
                    check_field("data_out", want.data, got.data);
                    check_field("last_element", 64'(want.last), 64'(got.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (elem.valid && elem.ready) || (addr.valid && addr.ready)
            || (cfg.valid && cfg.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("no handshake for %0d cycles, %0d words still expected",
                     quiet_cycles, nz_addr_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic put_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [DIM_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
    endtask

    task automatic program_shape(input logic [DIM_W-1:0] cols, rows, batches, tw_word, prow);
        @(posedge clk);
        put_reg(REG_NUM_COLS, cols);
        put_reg(REG_NUM_ROWS, rows);
        put_reg(REG_NUM_BATCHES, batches);
        put_reg(REG_TILE_WIDTH, tw_word);
        put_reg(REG_PADDED_ROWS, prow);
        cfg.valid <= 1'b0;
        shapes_run++;
    endtask

    task automatic push_words(input int n, input bit corners);
        logic [DATA_W-1:0] w;
        @(negedge clk);
        for (int k = 0; k < n; k++)
        begin
            if (!corners)
                w = {$urandom, $urandom};
            else
                case (k % 4)
                    0: w = '0;
                    1: w = '1;
                    2: w = {(DATA_W/2){2'b01}};
                    default: w = {(DATA_W/2){2'b10}};
                endcase
            element_q.insert(element_q.size(), w);
        end
    endtask

    task automatic drain();
        do @(negedge clk); while (element_q.size() > 0 || nz_addr_q.size() > 0 || elem.valid);
    endtask

    function automatic logic [DIM_W-1:0] pick_tile_word();
        logic [TW_W-1:0] tw;
        case ($urandom_range(7))
            5:       tw = TW_W'($urandom_range(1, 7) * 2 + 1);
            6:       tw = TW_W'($urandom_range(1));
            7:       tw = TW_W'($urandom_range(64, 127));
            default: tw = TW_W'($urandom_range(1, 8) * 2);
        endcase
        if ($urandom_range(3) == 0)
            return {DIM_W'($urandom_range(1023)) << TW_W} | DIM_W'(tw);
        return DIM_W'(tw);
    endfunction

    initial
    begin : stimulus
        int queued;
        int n;
        int tensor_len;
        logic [DIM_W-1:0] c, r, b, p;
        rst_n         <= 1'b0;
        cfg.valid     <= 1'b0;
        cfg.index     <= REG_NUM_COLS;
        cfg.data      <= '0;
        send_idle_pct = 27;
        recv_idle_pct = 65;
        fail_count    = 0;
        words_checked = 0;
        tensor_ends   = 0;
        shapes_run    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset shape: every word ends a tensor
        push_words(2, 1'b1);
        drain();
        // tile, row and batch wrap on a small tensor
        program_shape(3, 2, 2, 2, 2);
        push_words(12, 1'b1);
        drain();
        // zero dimensions and tile width below two
        program_shape(0, 0, 0, 1, 0);
        push_words(2, 1'b1);
        drain();
        // dimensions and tile width above range, left mid-tensor
        program_shape(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h0007F, 17'h1FFFF);
        push_words(3, 1'b1);
        drain();
        // shrink under running counters, odd tile width, padded rows below rows
        program_shape(2, 3, 1, 3, 1);
        push_words(3, 1'b1);
        drain();

        queued = 0;
        while (queued < ELEM_TARGET)
        begin
            if (queued >= (2 * ELEM_TARGET) / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (queued >= ELEM_TARGET / 3)
            begin
                send_idle_pct = 65;
                recv_idle_pct = 27;
            end
            case ($urandom_range(9))
                0:
                begin
                    c = DIM_W'($urandom);
                    r = DIM_W'($urandom);
                    b = DIM_W'($urandom);
                    p = DIM_W'($urandom);
                    program_shape(c, r, b, DIM_W'($urandom), p);
                    n = $urandom_range(5, 30);
                end
                1:
                begin
                    program_shape(1, 1, DIM_W'($urandom_range(1000, 65536)), DIM_W'(TILE_MAX),
                                  DIM_W'($urandom_range(30000, 65536)));
                    n = $urandom_range(40, 80);
                end
                default:
                begin
                    c = DIM_W'($urandom_range(0, ($urandom_range(3) == 0) ? 40 : 12));
                    r = DIM_W'($urandom_range(0, 6));
                    b = DIM_W'($urandom_range(0, 4));
                    p = DIM_W'($urandom_range(0, 32'(r) + 8));
                    program_shape(c, r, b, pick_tile_word(), p);
                    tensor_len = clamp_dim(c) * clamp_dim(r) * clamp_dim(b);
                    n = tensor_len * $urandom_range(1, 2) + $urandom_range(0, 3);
                    if (n > 200)
                        n = $urandom_range(100, 200);
                end
            endcase
            push_words(n, 1'b0);
            queued += n;
            drain();
        end

        drain();
        repeat (5) @(negedge clk);
        $display("Checked %0d address words, %0d of them tensor ends, over %0d shapes",
                 words_checked, tensor_ends, shapes_run);
        $display("Shapes ranged from clamped zero sizes to 65536-wide tensors");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
